@@ src/tlwc_pkg.sv @@
// package for the two-level write-back cache
// holds payload structs, controller state enum, command/status structs and defaults
`default_nettype none
package tlwc_pkg;

    localparam int WORD_BYTES_D   = 4;
    localparam int LINE_BYTES_D   = 16;
    localparam int NEAR_BYTES_D   = 256;
    localparam int FAR_BYTES_D    = 512;
    localparam int FAR_WAYS_D     = 2;
    localparam int MEMORY_BYTES_D = 65536;

    localparam int ADDR_W = 16;
    localparam int COST_W = 10;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_L1_READ   = 3'd0;
    localparam logic [2:0] REG_L1_WRITE  = 3'd1;
    localparam logic [2:0] REG_L2_MISS   = 3'd2;
    localparam logic [2:0] REG_MEM_READ  = 3'd3;
    localparam logic [2:0] REG_MEM_WRITE = 3'd4;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] address;
        logic [31:0] write_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_word;
        logic [31:0] elapsed_time;
        logic        access_error;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L1_RD,      // read l1 line
        ST_L1_CHK,     // hit check
        ST_WB_SET,     // l2 lookup for l1 victim writeback
        ST_WB_RD,
        ST_WB_CHK,
        ST_WB_VRD,     // read l2 victim line
        ST_WB_MW,      // memory write of l2 victim
        ST_WB_MR,      // memory read into l2 (write miss)
        ST_WB_WR,      // write l1 victim into l2
        ST_RF_SET,     // l2 lookup for refill
        ST_RF_RD,
        ST_RF_CHK,
        ST_RF_VRD,
        ST_RF_MW,
        ST_RF_MR,
        ST_RF_FILL,    // write filled line into l2
        ST_RF_L1,      // write refilled line into l1
        ST_WORD,       // word read/write in l1
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic l1_rd;
        logic wb_sel;      // l2 access uses l1 victim address
        logic l2_rd;
        logic l2_lookup;
        logic vict_rd;
        logic mem_wr;
        logic mem_rd;
        logic l2_wr_block; // write l1 victim data, dirty
        logic l2_fill;     // write memory data into l2 (clean read fill)
        logic l2_hit_rd;   // read hit: stamp and copy to buffer
        logic l1_fill;
        logic word_op;
        logic done;
        logic mem_step;    // byte step of memory transfer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clearing;    // backing memory clearing pass after reset
        logic bad;
        logic l1_hit;
        logic l1_dirty;
        logic l2_hit;
        logic l2_vdirty;
        logic mem_last;
    } t_sts;

endpackage
`default_nettype wire

@@ src/two_level_writeback_cache.sv @@
// two-level write-back cache: direct-mapped l1 over a set-associative lru l2 over memory
// an l1 hit reads l1, checks the tag and does the word op; an error skips the word op;
// a miss writes a dirty l1 victim to l2, then refills l1 via l2 (one memory byte a cycle)
// one access at a time; the next one is taken in the cycle its result shows on o_valid
// synchronous active-low reset clears valid/dirty flags and the time counter; then busy
// stays high while all MEMORY_BYTES (65536 by default) bytes of backing memory are zeroed
`default_nettype none
module two_level_writeback_cache #(
    parameter int LINE_BYTES   = tlwc_pkg::LINE_BYTES_D,
    parameter int NEAR_BYTES   = tlwc_pkg::NEAR_BYTES_D,
    parameter int FAR_BYTES    = tlwc_pkg::FAR_BYTES_D,
    parameter int FAR_WAYS     = tlwc_pkg::FAR_WAYS_D,
    parameter int MEMORY_BYTES = tlwc_pkg::MEMORY_BYTES_D
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tlwc_pkg::t_in_item            i_item,
    output logic                               o_valid,
    output tlwc_pkg::t_out_item                o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tlwc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tlwc_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [COST_W-1:0] r_c0, r_c1, r_c2, r_c3, r_c4;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= 10'd1; r_c1 <= 10'd1; r_c2 <= 10'd10; r_c3 <= 10'd100; r_c4 <= 10'd50;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_L1_READ:   r_c0 <= pwdata[COST_W-1:0];
                REG_L1_WRITE:  r_c1 <= pwdata[COST_W-1:0];
                REG_L2_MISS:   r_c2 <= pwdata[COST_W-1:0];
                REG_MEM_READ:  r_c3 <= pwdata[COST_W-1:0];
                REG_MEM_WRITE: r_c4 <= pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_L1_READ:   prdata = 32'(r_c0);
            REG_L1_WRITE:  prdata = 32'(r_c1);
            REG_L2_MISS:   prdata = 32'(r_c2);
            REG_MEM_READ:  prdata = 32'(r_c3);
            REG_MEM_WRITE: prdata = 32'(r_c4);
            default:       prdata = 32'h0;
        endcase
    end

    tlwc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .i_sts(sts), .o_cmd(cmd)
    );

    tlwc_dp #(
        .LINE_BYTES(LINE_BYTES), .NEAR_BYTES(NEAR_BYTES), .FAR_BYTES(FAR_BYTES),
        .FAR_WAYS(FAR_WAYS), .MEMORY_BYTES(MEMORY_BYTES)
    ) u_dp (
        .i_clk, .i_rst_n, .i_item, .i_cmd(cmd),
        .i_l1_rd_cost(r_c0), .i_l1_wr_cost(r_c1), .i_l2_miss_cost(r_c2),
        .i_mem_rd_cost(r_c3), .i_mem_wr_cost(r_c4),
        .o_sts(sts), .o_valid, .o_result
    );

endmodule
`default_nettype wire

@@ src/tlwc_ctrl.sv @@
// controller state machine for the two-level write-back cache
// depends on tlwc_pkg for state, command and status types
`default_nettype none
module tlwc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tlwc_pkg::t_sts   i_sts,
    output tlwc_pkg::t_cmd        o_cmd
);
    import tlwc_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE) || i_sts.clearing;
        unique case (r_state)
            ST_IDLE: begin
                if (start && !i_sts.clearing) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_L1_RD;
                end
            end
            ST_L1_RD: begin
                o_cmd.l1_rd = 1'b1;
                n_state = ST_L1_CHK;
            end
            ST_L1_CHK: begin
                if (i_sts.bad || i_sts.l1_hit) n_state = i_sts.bad ? ST_DONE : ST_WORD;
                else if (i_sts.l1_dirty) n_state = ST_WB_SET;
                else n_state = ST_RF_SET;
            end
            ST_WB_SET: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.l2_rd = 1'b1;
                n_state = ST_WB_RD;
            end
            ST_WB_RD: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.l2_lookup = 1'b1;
                n_state = ST_WB_CHK;
            end
            ST_WB_CHK: begin
                o_cmd.wb_sel = 1'b1;
                if (i_sts.l2_hit) n_state = ST_WB_WR;
                else n_state = ST_WB_VRD;
            end
            ST_WB_VRD: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.vict_rd = 1'b1;
                n_state = i_sts.l2_vdirty ? ST_WB_MW : ST_WB_MR;
            end
            ST_WB_MW: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.mem_wr = 1'b1;
                o_cmd.mem_step = 1'b1;
                if (i_sts.mem_last) n_state = ST_WB_MR;
            end
            ST_WB_MR: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.mem_rd = 1'b1;
                o_cmd.mem_step = 1'b1;
                if (i_sts.mem_last) n_state = ST_WB_WR;
            end
            ST_WB_WR: begin
                o_cmd.wb_sel = 1'b1;
                o_cmd.l2_wr_block = 1'b1;
                n_state = ST_RF_SET;
            end
            ST_RF_SET: begin
                o_cmd.l2_rd = 1'b1;
                n_state = ST_RF_RD;
            end
            ST_RF_RD: begin
                o_cmd.l2_lookup = 1'b1;
                n_state = ST_RF_CHK;
            end
            ST_RF_CHK: begin
                if (i_sts.l2_hit) begin
                    o_cmd.l2_hit_rd = 1'b1;
                    n_state = ST_RF_L1;
                end else begin
                    n_state = ST_RF_VRD;
                end
            end
            ST_RF_VRD: begin
                o_cmd.vict_rd = 1'b1;
                n_state = i_sts.l2_vdirty ? ST_RF_MW : ST_RF_MR;
            end
            ST_RF_MW: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.mem_step = 1'b1;
                if (i_sts.mem_last) n_state = ST_RF_MR;
            end
            ST_RF_MR: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.mem_step = 1'b1;
                if (i_sts.mem_last) n_state = ST_RF_FILL;
            end
            ST_RF_FILL: begin
                o_cmd.l2_fill = 1'b1;
                n_state = ST_RF_L1;
            end
            ST_RF_L1: begin
                o_cmd.l1_fill = 1'b1;
                n_state = ST_WORD;
            end
            ST_WORD: begin
                o_cmd.word_op = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ src/tlwc_dp.sv @@
// datapath for the two-level write-back cache: l1, l2, backing memory, time counter
// depends on tlwc_pkg; driven by tlwc_ctrl through t_cmd/t_sts
`default_nettype none
module tlwc_dp #(
    parameter int LINE_BYTES   = tlwc_pkg::LINE_BYTES_D,
    parameter int NEAR_BYTES   = tlwc_pkg::NEAR_BYTES_D,
    parameter int FAR_BYTES    = tlwc_pkg::FAR_BYTES_D,
    parameter int FAR_WAYS     = tlwc_pkg::FAR_WAYS_D,
    parameter int MEMORY_BYTES = tlwc_pkg::MEMORY_BYTES_D
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tlwc_pkg::t_in_item               i_item,
    input  wire tlwc_pkg::t_cmd                   i_cmd,
    input  wire logic [tlwc_pkg::COST_W-1:0]      i_l1_rd_cost,
    input  wire logic [tlwc_pkg::COST_W-1:0]      i_l1_wr_cost,
    input  wire logic [tlwc_pkg::COST_W-1:0]      i_l2_miss_cost,
    input  wire logic [tlwc_pkg::COST_W-1:0]      i_mem_rd_cost,
    input  wire logic [tlwc_pkg::COST_W-1:0]      i_mem_wr_cost,
    output tlwc_pkg::t_sts                        o_sts,
    output logic                                  o_valid,
    output tlwc_pkg::t_out_item                   o_result
);
    import tlwc_pkg::*;

    localparam int LINE_BITS = 8 * LINE_BYTES;
    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int L1_N    = NEAR_BYTES / LINE_BYTES;
    localparam int L1_IW   = $clog2(L1_N);
    localparam int L2_S    = FAR_BYTES / (LINE_BYTES * FAR_WAYS);
    localparam int L2_SW   = (L2_S > 1) ? $clog2(L2_S) : 1;
    localparam int WAY_W   = $clog2(FAR_WAYS);
    localparam int L2_N    = L2_S * FAR_WAYS;
    localparam int L2_NW   = $clog2(L2_N);
    localparam int MA_W    = $clog2(MEMORY_BYTES);
    localparam int LA_W    = MA_W - OFF_W;          // line address width
    localparam int T1_W    = LA_W - L1_IW;
    localparam int T2_W    = LA_W - $clog2(L2_S);
    localparam int WPL     = LINE_BYTES / WORD_BYTES_D;
    localparam int WSEL_W  = $clog2(WPL);

    // request registers
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [31:0]       r_wdata;
    logic              r_bad;
    logic [31:0]       r_time;

    // l1 storage: flags in flops, tags and data in memories
    logic [L1_N-1:0]  r_l1_valid, r_l1_dirty;
    logic [T1_W-1:0]  m_l1_tag  [L1_N];
    logic [LINE_BITS-1:0] m_l1_data [L1_N];
    logic [T1_W-1:0]  r_l1_tag_q;
    logic [LINE_BITS-1:0] r_l1_line;

    // l2 storage
    logic [L2_N-1:0]  r_l2_valid, r_l2_dirty;
    logic [T2_W-1:0]  m_l2_tag   [L2_N];
    logic [31:0]      m_l2_stamp [L2_N];
    logic [LINE_BITS-1:0] m_l2_data [L2_N];
    logic [T2_W-1:0]  r_l2_tag_q   [FAR_WAYS];
    logic [31:0]      r_l2_stamp_q [FAR_WAYS];
    logic [WAY_W-1:0] r_way;
    logic             r_hit;
    logic [LINE_BITS-1:0] r_l2_vline;
    logic [LINE_BITS-1:0] r_buf;       // line moving between levels/memory

    // backing memory, zeroed by a clearing pass after reset
    logic [7:0]        m_mem [MEMORY_BYTES];
    logic              r_clr;
    logic [MA_W-1:0]   r_clr_addr;
    logic [OFF_W-1:0]  r_mcnt;
    logic [7:0]        r_mem_q;
    logic              r_mem_rdv;
    logic [OFF_W-1:0]  r_mcnt_d;

    // address fields
    logic [LA_W-1:0]  req_la, l1v_la, l2_la, l2v_la;
    logic [L1_IW-1:0] l1_idx;
    logic [T1_W-1:0]  req_t1;
    logic [L2_SW-1:0] l2_set;
    logic [T2_W-1:0]  l2_tag;
    logic [31:0]      ext_addr;

    assign ext_addr = 32'(r_addr);
    assign req_la = ext_addr[OFF_W +: LA_W];
    assign l1_idx = req_la[L1_IW-1:0];
    assign req_t1 = req_la[LA_W-1 -: T1_W];
    assign l1v_la = {r_l1_tag_q, l1_idx};
    assign l2_la  = i_cmd.wb_sel ? l1v_la : req_la;
    assign l2_set = (L2_S > 1) ? L2_SW'(l2_la % LA_W'(L2_S)) : '0;
    assign l2_tag = T2_W'(l2_la >> $clog2(L2_S));
    assign l2v_la = LA_W'({r_l2_tag_q[r_way], l2_set} >> (L2_S > 1 ? 0 : 1));

    function automatic logic [L2_NW-1:0] slot(input logic [L2_SW-1:0] s,
                                              input logic [WAY_W-1:0] w);
        slot = L2_NW'((L2_NW+1)'(s) * (L2_NW+1)'(FAR_WAYS) + (L2_NW+1)'(w));
    endfunction

    // request capture and decode
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_item.command;
            r_addr  <= i_item.address;
            r_wdata <= i_item.write_word;
            r_bad   <= (i_item.address[1:0] != 2'b00) ||
                       (32'(i_item.address) > 32'(MEMORY_BYTES - WORD_BYTES_D));
        end
    end

    // l1 read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.l1_rd) begin
            r_l1_tag_q <= m_l1_tag[l1_idx];
        end
        if (i_cmd.l1_rd || i_cmd.l1_fill) begin
            r_l1_line <= i_cmd.l1_fill ? r_buf : m_l1_data[l1_idx];
        end
    end

    // l1 write port
    logic [LINE_BITS-1:0] word_line;
    always_comb begin
        word_line = r_l1_line;
        word_line[32*r_addr[OFF_W-1:2] +: 32] = r_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.l1_fill) begin
            m_l1_tag[l1_idx]  <= req_t1;
            m_l1_data[l1_idx] <= r_buf;
        end else if (i_cmd.word_op && r_cmd == CMD_WRITE) begin
            m_l1_data[l1_idx] <= word_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_valid <= '0;
            r_l1_dirty <= '0;
        end else if (i_cmd.l1_fill) begin
            r_l1_valid[l1_idx] <= 1'b1;
            r_l1_dirty[l1_idx] <= 1'b0;
        end else if (i_cmd.word_op && r_cmd == CMD_WRITE) begin
            r_l1_dirty[l1_idx] <= 1'b1;
        end
    end

    assign o_sts.bad      = r_bad;
    assign o_sts.l1_hit   = r_l1_valid[l1_idx] && (r_l1_tag_q == req_t1);
    assign o_sts.l1_dirty = r_l1_dirty[l1_idx];

    // l2 tag/stamp read per way
    always_ff @(posedge i_clk) begin
        if (i_cmd.l2_rd) begin
            for (int w = 0; w < FAR_WAYS; w++) begin
                r_l2_tag_q[w]   <= m_l2_tag[slot(l2_set, WAY_W'(w))];
                r_l2_stamp_q[w] <= m_l2_stamp[slot(l2_set, WAY_W'(w))];
            end
        end
    end

    // hit and victim selection
    logic             hit_c;
    logic [WAY_W-1:0] hway_c, vway_c, inv_c, lru_c;
    logic             inv_f;
    always_comb begin
        hit_c = 1'b0; hway_c = '0; inv_f = 1'b0; inv_c = '0; lru_c = '0;
        for (int w = FAR_WAYS-1; w >= 0; w--) begin
            if (r_l2_valid[slot(l2_set, WAY_W'(w))] && r_l2_tag_q[w] == l2_tag) begin
                hit_c = 1'b1; hway_c = WAY_W'(w);
            end
            if (!r_l2_valid[slot(l2_set, WAY_W'(w))]) begin
                inv_f = 1'b1; inv_c = WAY_W'(w);
            end
        end
        for (int w = 1; w < FAR_WAYS; w++) begin
            if (r_l2_stamp_q[w] < r_l2_stamp_q[lru_c]) lru_c = WAY_W'(w);
        end
        vway_c = inv_f ? inv_c : lru_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.l2_lookup) begin
            r_hit <= hit_c;
            r_way <= hit_c ? hway_c : vway_c;
        end
    end

    assign o_sts.l2_hit   = r_hit;
    assign o_sts.l2_vdirty = r_l2_dirty[slot(l2_set, r_way)];

    // l2 data read (victim or hit line)
    always_ff @(posedge i_clk) begin
        if (i_cmd.vict_rd || i_cmd.l2_hit_rd) begin
            r_l2_vline <= m_l2_data[slot(l2_set, r_way)];
        end
    end

    // move buffer: memory bytes, l2 hit line, l1 victim
    always_ff @(posedge i_clk) begin
        if (r_mem_rdv) begin
            r_buf[8*r_mcnt_d +: 8] <= r_mem_q;
        end else if (i_cmd.l2_hit_rd) begin
            r_buf <= m_l2_data[slot(l2_set, r_way)];
        end else if (i_cmd.l1_rd) begin
            r_buf <= m_l1_data[l1_idx];
        end
    end

    // filled line with the last memory byte merged in
    logic [LINE_BITS-1:0] fill_line;
    always_comb begin
        fill_line = r_buf;
        if (r_mem_rdv) fill_line[8*r_mcnt_d +: 8] = r_mem_q;
    end

    // l2 writes: l1 victim line, memory fill line, or the stamp of a read hit
    always_ff @(posedge i_clk) begin
        if (i_cmd.l2_wr_block) begin
            m_l2_data[slot(l2_set, r_way)] <= r_l1_line;
            m_l2_tag[slot(l2_set, r_way)]  <= l2_tag;
            m_l2_stamp[slot(l2_set, r_way)] <= r_time + 32'(i_l1_wr_cost);
        end else if (i_cmd.l2_fill) begin
            m_l2_data[slot(l2_set, r_way)] <= fill_line;
            m_l2_tag[slot(l2_set, r_way)]  <= l2_tag;
            m_l2_stamp[slot(l2_set, r_way)] <= r_time;
        end else if (i_cmd.l2_hit_rd) begin
            m_l2_stamp[slot(l2_set, r_way)] <= r_time + 32'(i_l1_rd_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_valid <= '0;
            r_l2_dirty <= '0;
        end else if (i_cmd.l2_wr_block) begin
            r_l2_valid[slot(l2_set, r_way)] <= 1'b1;
            r_l2_dirty[slot(l2_set, r_way)] <= 1'b1;
        end else if (i_cmd.l2_fill) begin
            r_l2_valid[slot(l2_set, r_way)] <= 1'b1;
            r_l2_dirty[slot(l2_set, r_way)] <= 1'b0;
        end
    end

    // clearing pass over backing memory, one byte per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MA_W'(MEMORY_BYTES-1)) r_clr <= 1'b0;
        end
    end

    assign o_sts.clearing = r_clr;

    // backing memory byte transfer, one byte per cycle
    logic [LA_W-1:0] mem_la;
    assign mem_la = i_cmd.mem_wr ? l2v_la : l2_la;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt    <= '0;
            r_mem_rdv <= 1'b0;
        end else begin
            r_mem_rdv <= i_cmd.mem_rd;
            r_mcnt    <= i_cmd.mem_step ? r_mcnt + 1'b1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcnt_d   <= r_mcnt;
        if (r_clr) begin
            m_mem[r_clr_addr] <= 8'h00;
        end else if (i_cmd.mem_wr) begin
            m_mem[{mem_la, r_mcnt}] <= r_l2_vline[8*r_mcnt +: 8];
        end
        r_mem_q <= m_mem[{mem_la, r_mcnt}];
    end

    assign o_sts.mem_last = (r_mcnt == OFF_W'(LINE_BYTES-1));

    // time counter and result
    logic [31:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            if (i_cmd.mem_wr && o_sts.mem_last) r_time <= r_time + 32'(i_mem_wr_cost);
            else if (i_cmd.mem_rd && o_sts.mem_last) r_time <= r_time + 32'(i_mem_rd_cost);
            else if (i_cmd.l2_wr_block) r_time <= r_time + 32'(i_l1_wr_cost);
            else if (i_cmd.l2_fill) r_time <= r_time + 32'(i_l2_miss_cost);
            else if (i_cmd.l2_hit_rd) r_time <= r_time + 32'(i_l1_rd_cost);
            else if (i_cmd.word_op) begin
                r_time <= r_time + 32'(r_cmd == CMD_WRITE ? i_l1_wr_cost : i_l1_rd_cost);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.word_op) begin
            r_rdata <= (r_cmd == CMD_WRITE) ? 32'h0 : r_l1_line[32*r_addr[OFF_W-1:2] +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_cmd.done;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_result.read_word    <= r_bad ? 32'h0 : r_rdata;
            o_result.elapsed_time <= r_time;
            o_result.access_error <= r_bad;
        end
    end

endmodule
`default_nettype wire

@@ sim/two_level_writeback_cache_tb.sv @@
// testbench for the two-level write-back cache: random and directed word accesses,
// checked against a behavioral model of both cache levels and memory kept in a scoreboard
// depends on tlwc_pkg and two_level_writeback_cache
`default_nettype none
module two_level_writeback_cache_tb;
    import tlwc_pkg::*;

    // scoreboard: behavioral cache model and the queue of expected results
    class cache_scoreboard;
        bit [9:0]   cost[5];
        bit         near_valid[16];
        bit         near_dirty[16];
        bit [7:0]   near_tag[16];
        bit [127:0] near_line[16];
        bit         far_valid[16][2];
        bit         far_dirty[16][2];
        bit [7:0]   far_tag[16][2];
        bit [31:0]  far_stamp[16][2];
        bit [127:0] far_line[16][2];
        bit [7:0]   mem[65536];
        bit [31:0]  clock_count;
        t_out_item  pending[$];
        int         errors;

        function new();
            cost[REG_L1_READ]   = 1;
            cost[REG_L1_WRITE]  = 1;
            cost[REG_L2_MISS]   = 10;
            cost[REG_MEM_READ]  = 100;
            cost[REG_MEM_WRITE] = 50;
            clock_count = 0;
            errors = 0;
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < 16; i++) begin
                near_valid[i] = 0; near_dirty[i] = 0; near_tag[i] = 0; near_line[i] = '0;
                for (int w = 0; w < 2; w++) begin
                    far_valid[i][w] = 0; far_dirty[i][w] = 0; far_tag[i][w] = 0;
                    far_stamp[i][w] = 0; far_line[i][w] = '0;
                end
            end
        endfunction

        // level two access of one line; returns the line on a read
        function bit [127:0] far_access(bit wr, bit [15:0] base, bit [127:0] data);
            bit [7:0]   tg;
            bit [3:0]   st;
            int         w;
            bit         hit;
            bit [15:0]  vbase;
            bit [127:0] ret;
            tg = base[15:8];
            st = base[7:4];
            hit = 0;
            ret = '0;
            w = 0;
            for (int i = 0; i < 2; i++)
                if (!hit && far_valid[st][i] && far_tag[st][i] == tg) begin
                    hit = 1;
                    w = i;
                end
            if (!hit) begin
                // first invalid way, else oldest stamp with ties to the lower way
                w = 2;
                for (int i = 1; i >= 0; i--)
                    if (!far_valid[st][i]) w = i;
                if (w == 2) begin
                    w = 0;
                    if (far_stamp[st][1] < far_stamp[st][0]) w = 1;
                end
                if (far_dirty[st][w]) begin
                    vbase = {far_tag[st][w], st, 4'h0};
                    for (int k = 0; k < 16; k++) mem[vbase + k] = far_line[st][w][8*k +: 8];
                    clock_count += cost[REG_MEM_WRITE];
                end
                for (int k = 0; k < 16; k++)
                    far_line[st][w][8*k +: 8] = mem[{base[15:4], 4'h0} + k];
                clock_count += cost[REG_MEM_READ];
                far_valid[st][w] = 1;
                far_dirty[st][w] = 0;
                far_tag[st][w] = tg;
                far_stamp[st][w] = clock_count;
                if (wr) begin
                    far_line[st][w] = data;
                    clock_count += cost[REG_L1_WRITE];
                    far_dirty[st][w] = 1;
                    far_stamp[st][w] = clock_count;
                end else begin
                    ret = far_line[st][w];
                    clock_count += cost[REG_L2_MISS];
                end
            end else if (wr) begin
                far_line[st][w] = data;
                clock_count += cost[REG_L1_WRITE];
                far_dirty[st][w] = 1;
                far_stamp[st][w] = clock_count;
            end else begin
                ret = far_line[st][w];
                clock_count += cost[REG_L1_READ];
                far_stamp[st][w] = clock_count;
            end
            return ret;
        endfunction

        // work out the result of one accepted transaction
        function void note_input(t_in_item it);
            t_out_item r;
            bit [7:0]  tg;
            bit [3:0]  ix;
            bit [127:0] dummy;
            r = '0;
            if (it.address[1:0] != 2'b00) begin
                r.elapsed_time = clock_count;
                r.access_error = 1'b1;
                pending.push_back(r);
                return;
            end
            tg = it.address[15:8];
            ix = it.address[7:4];
            if (!(near_valid[ix] && near_tag[ix] == tg)) begin
                if (near_dirty[ix])
                    dummy = far_access(1'b1, {near_tag[ix], ix, 4'h0}, near_line[ix]);
                near_line[ix] = far_access(1'b0, {it.address[15:4], 4'h0}, '0);
                near_valid[ix] = 1;
                near_dirty[ix] = 0;
                near_tag[ix] = tg;
            end
            if (it.command == CMD_WRITE) begin
                near_line[ix][8*it.address[3:0] +: 32] = it.write_word;
                clock_count += cost[REG_L1_WRITE];
                near_dirty[ix] = 1;
            end else begin
                r.read_word = near_line[ix][8*it.address[3:0] +: 32];
                clock_count += cost[REG_L1_READ];
            end
            r.elapsed_time = clock_count;
            pending.push_back(r);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.read_word !== want.read_word) begin
                $error("read_word expected %h actual %h", want.read_word, got.read_word);
                errors++;
            end
            if (got.elapsed_time !== want.elapsed_time) begin
                $error("elapsed_time expected %h actual %h",
                       want.elapsed_time, got.elapsed_time);
                errors++;
            end
            if (got.access_error !== want.access_error) begin
                $error("access_error expected %b actual %b",
                       want.access_error, got.access_error);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_item           i_item;
    logic               o_valid;
    t_out_item          o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    cache_scoreboard sb;
    int sender_idle_pct;

    two_level_writeback_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // run limit
    initial begin
        #(12 * 2000000);
        $display("Test completed with failures");
        $finish;
    end

    // one transaction, held until accepted, then an optional random gap
    task automatic send_access(logic cmd, logic [15:0] addr, logic [31:0] data);
        t_in_item it;
        it.command = cmd;
        it.address = addr;
        it.write_word = data;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has come
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // register write over the apb port
    task automatic write_cost(logic [2:0] idx, logic [9:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {22'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.cost[idx] = val;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_costs(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                   logic [9:0] d, logic [9:0] e);
        write_cost(REG_L1_READ, a);
        write_cost(REG_L1_WRITE, b);
        write_cost(REG_L2_MISS, c);
        write_cost(REG_MEM_READ, d);
        write_cost(REG_MEM_WRITE, e);
    endtask

    // random address: mostly a few conflicting tags so both levels evict
    function automatic logic [15:0] pick_address();
        int r;
        logic [7:0] tg;
        r = $urandom_range(99);
        if (r < 8) return 16'($urandom);
        case ($urandom_range(5))
            0: tg = 8'h00;
            1: tg = 8'h01;
            2: tg = 8'h02;
            3: tg = 8'h03;
            4: tg = 8'hFF;
            default: tg = 8'($urandom);
        endcase
        return {tg, 4'($urandom_range(15)), 2'($urandom_range(3)), 2'b00};
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            send_access(1'($urandom_range(1)), pick_address(), $urandom);
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        sb = new();
        sender_idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edges, errors, dirty evictions through both levels
        send_access(CMD_READ, 16'h0000, 32'h0);
        send_access(CMD_WRITE, 16'hFFFC, 32'hFFFF_FFFF);
        send_access(CMD_READ, 16'hFFFC, 32'h0);
        send_access(CMD_READ, 16'h0001, 32'h0);
        send_access(CMD_WRITE, 16'h0002, 32'h1234_5678);
        send_access(CMD_READ, 16'hFFFF, 32'h0);
        send_access(CMD_WRITE, 16'hFFFD, 32'hFFFF_FFFF);
        for (int t = 0; t < 4; t++)
            send_access(CMD_WRITE, {8'(t), 4'h5, 4'h8}, 32'hA5A5_0000 | t);
        for (int t = 0; t < 4; t++)
            send_access(CMD_READ, {8'(t), 4'h5, 4'h8}, 32'h0);
        send_access(CMD_WRITE, 16'h0004, 32'h0000_0000);
        send_access(CMD_READ, 16'h0004, 32'h0);
        send_access(CMD_WRITE, 16'h0108, 32'h8000_0001);
        send_access(CMD_READ, 16'h0208, 32'h0);
        send_access(CMD_READ, 16'h0108, 32'h0);
        drain();

        // random phases over several cost settings and sender idle levels
        sender_idle_pct = 17;
        random_phase(250);
        drain();
        write_all_costs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        sender_idle_pct = 66;
        random_phase(250);
        drain();
        write_all_costs(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        sender_idle_pct = 0;
        random_phase(250);
        drain();
        write_all_costs(10'($urandom), 10'($urandom), 10'($urandom),
                        10'($urandom), 10'($urandom));
        sender_idle_pct = 17;
        random_phase(250);

        // let the last transaction settle
        drain();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
